// ===== rtl/ufc_pkg.sv =====
package ufc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int KEY_W         = 32;
  localparam int CNT_W         = 32;

  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0]   ENTRIES_EXT = (IDX_W + 1)'(TABLE_ENTRIES);

  // frame qualification constants
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [16:0] MIN_IP_LEN   = 17'd34;  // ethernet plus minimum ip header
  localparam logic [16:0] UDP_BASE_LEN = 17'd22;  // ethernet plus udp header

  localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(50);
  localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [CNT_W-1:0] COUNT_ONE    = CNT_W'(1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_NEW,
    RES_DROP
  } res_sel_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic     clr;
    logic     load;
    logic     rd;
    logic     step;
    logic     res_wr;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic qual_in;
    logic hit;
    logic empty;
    logic probe_last;
    logic out_free;
  } stat_t;

  // xor fold of the source address onto the table index, reduced below the depth
  function automatic idx_t hash_key(logic [KEY_W-1:0] key);
    logic [IDX_W-1:0] h;
    logic [IDX_W:0]   hx;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ key[i];
    end
    hx = {1'b0, h};
    if (hx >= ENTRIES_EXT) begin
      hx = hx - ENTRIES_EXT;
    end
    return hx[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/udp_per_source_flood_counter.sv =====
// udp per-source flood counter
//
// input channel: one word per received frame, a header summary (frame length,
// ethertype, ip protocol, ip header length in words, source address). output
// channel: exactly one result word per input word, in order: counted flag,
// new per-source count, alert flag and table-full drop flag. frames that are
// not complete ipv4/udp frames give an all-zero result and touch no state.
// cfg port: one write-only register, the alert threshold (50 after reset).
//
// sources live in a 1024-entry hashed table (one ram, one read and one write
// port) searched by linear probing, each probe a read state and a compare state.
// the block takes a new word only after the last one has handed its result to
// the output register; the probe loop through the table ram runs over the whole
// table when the table is full and the source is new.
// reset: a clearing pass sweeps the table ram with in_stall high; cfg writes are
// taken during it. the result sits in an output register, so while out_stall
// holds the result the block still takes the next word and works it up to the
// point of handing over its result.
module udp_per_source_flood_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_protocol,
  input  logic [3:0]  in_ip_header_words,
  input  logic [31:0] in_source_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_counted,
  output logic [31:0] out_source_count,
  output logic        out_alert,
  output logic        out_table_full_drop
);
  import ufc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: clearing pass, accept, probe loop, result handoff
  ufc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table ram, hash, compare, count update and output register
  ufc_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_frame_length     (in_frame_length),
    .in_ether_type       (in_ether_type),
    .in_ip_protocol      (in_ip_protocol),
    .in_ip_header_words  (in_ip_header_words),
    .in_source_address   (in_source_address),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_counted         (out_counted),
    .out_source_count    (out_source_count),
    .out_alert           (out_alert),
    .out_table_full_drop (out_table_full_drop)
  );

endmodule

// ===== rtl/ufc_ctrl.sv =====
module ufc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ufc_pkg::stat_t stat,
  output ufc_pkg::cmd_t  cmd
);
  import ufc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = RES_NONE;
    in_stall    = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.qual_in) begin
            state_nxt = ST_READ;
          end else begin
            cmd.res_wr  = 1'b1;
            cmd.res_sel = RES_NONE;
            state_nxt   = ST_EMIT;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.hit) begin
          cmd.res_wr  = 1'b1;
          cmd.res_sel = RES_HIT;
          state_nxt   = ST_EMIT;
        end else if (stat.empty) begin
          cmd.res_wr  = 1'b1;
          cmd.res_sel = RES_NEW;
          state_nxt   = ST_EMIT;
        end else if (stat.probe_last) begin
          cmd.res_wr  = 1'b1;
          cmd.res_sel = RES_DROP;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/ufc_datapath.sv =====
module ufc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ufc_pkg::cmd_t                cmd,
  output ufc_pkg::stat_t               stat,
  input  logic                         cfg_wr_en,
  input  logic [ufc_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic [15:0]                  in_frame_length,
  input  logic [15:0]                  in_ether_type,
  input  logic [7:0]                   in_ip_protocol,
  input  logic [3:0]                   in_ip_header_words,
  input  logic [ufc_pkg::KEY_W-1:0]    in_source_address,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         out_counted,
  output logic [ufc_pkg::CNT_W-1:0]    out_source_count,
  output logic                         out_alert,
  output logic                         out_table_full_drop
);
  import ufc_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  logic [CNT_W-1:0] thr_r;
  idx_t             addr_r, addr_inc;
  idx_t             probe_r;
  logic [KEY_W-1:0] src_r;
  entry_t           rd_q;

  logic             res_counted_r, res_alert_r, res_drop_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic             res_counted_nxt, res_alert_nxt, res_drop_nxt;
  logic [CNT_W-1:0] res_cnt_nxt, hit_cnt;

  logic             out_valid_r, out_counted_r, out_alert_r, out_drop_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic             wr_en;
  entry_t           wr_data;
  logic [16:0]      len_ext;

  // frame qualification on the incoming word
  assign len_ext      = {1'b0, in_frame_length};
  assign stat.qual_in = (in_ether_type == ETYPE_IPV4) && (in_ip_protocol == PROTO_UDP) &&
                        (len_ext >= MIN_IP_LEN) &&
                        (len_ext >= UDP_BASE_LEN + {11'd0, in_ip_header_words, 2'b00});

  assign addr_inc = (addr_r == IDX_LAST) ? '0 : addr_r + idx_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // probe address doubles as the sweep pointer of the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      probe_r <= '0;
    end else if (cmd.clr || cmd.step) begin
      addr_r  <= addr_inc;
      probe_r <= probe_r + idx_t'(1);
    end else if (cmd.load) begin
      addr_r  <= hash_key(in_source_address);
      probe_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= in_source_address;
    end
  end

  assign hit_cnt = (rd_q.count == COUNT_MAX) ? rd_q.count : rd_q.count + COUNT_ONE;

  assign stat.clr_last   = (addr_r == IDX_LAST);
  assign stat.hit        = rd_q.valid && (rd_q.key == src_r);
  assign stat.empty      = !rd_q.valid;
  assign stat.probe_last = (probe_r == IDX_LAST);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (cmd.clr) begin
      wr_en = 1'b1;
    end else if (cmd.res_wr && (cmd.res_sel == RES_HIT)) begin
      wr_en   = 1'b1;
      wr_data = '{valid: 1'b1, key: src_r, count: hit_cnt};
    end else if (cmd.res_wr && (cmd.res_sel == RES_NEW)) begin
      wr_en   = 1'b1;
      wr_data = '{valid: 1'b1, key: src_r, count: COUNT_ONE};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q <= mem[addr_r];
    end
  end

  // result formation
  always_comb begin
    res_counted_nxt = 1'b1;
    res_drop_nxt    = 1'b0;
    res_cnt_nxt     = COUNT_ONE;
    case (cmd.res_sel)
      RES_NONE: begin
        res_counted_nxt = 1'b0;
        res_cnt_nxt     = '0;
      end
      RES_HIT: begin
        res_cnt_nxt = hit_cnt;
      end
      RES_NEW: begin
        res_cnt_nxt = COUNT_ONE;
      end
      RES_DROP: begin
        res_drop_nxt = 1'b1;
      end
      default: begin
        res_counted_nxt = 1'b0;
        res_cnt_nxt     = '0;
      end
    endcase
    res_alert_nxt = res_counted_nxt && (res_cnt_nxt == thr_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      res_counted_r <= res_counted_nxt;
      res_cnt_r     <= res_cnt_nxt;
      res_alert_r   <= res_alert_nxt;
      res_drop_r    <= res_drop_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_counted_r <= res_counted_r;
      out_cnt_r     <= res_cnt_r;
      out_alert_r   <= res_alert_r;
      out_drop_r    <= res_drop_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_counted         = out_counted_r;
  assign out_source_count    = out_cnt_r;
  assign out_alert           = out_alert_r;
  assign out_table_full_drop = out_drop_r;

endmodule

// ===== rtl/ufc_checker.sv =====
module ufc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_counted,
  input logic [31:0] out_source_count,
  input logic        out_alert,
  input logic        out_table_full_drop
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word withdrawn while stalled");

  // a stalled count does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_source_count))
    else $error("count changed while stalled");

  // uncounted frames give an all-zero word
  a_uncounted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_counted |->
      (out_source_count == 32'd0) && !out_alert && !out_table_full_drop)
    else $error("uncounted frame with nonzero fields");

  // a dropped new source reports a count of one
  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full_drop |-> out_counted && (out_source_count == 32'd1))
    else $error("table-full drop with wrong count");

  // a counted frame never reports zero
  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_counted |-> (out_source_count != 32'd0))
    else $error("counted frame with zero count");

endmodule

bind udp_per_source_flood_counter ufc_checker u_ufc_checker (.*);

// ===== bench/tb_udp_per_source_flood_counter.sv =====
`timescale 1ns / 100ps

module tb_udp_per_source_flood_counter;
  import ufc_pkg::*;

  localparam int STUCK_LIMIT = 20000;  // cycles with no word moving on either side
  localparam int SETTLE      = 12;

  // one frame header summary, as it sits on the input word
  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_header_words;
    logic [31:0] source_address;
  } frame_hdr_t;

  // one result word
  typedef struct packed {
    logic        counted;
    logic [31:0] source_count;
    logic        alert;
    logic        table_full_drop;
  } flood_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_frame_length = '0;
  logic [15:0] in_ether_type = '0;
  logic [7:0]  in_ip_protocol = '0;
  logic [3:0]  in_ip_header_words = '0;
  logic [31:0] in_source_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_counted;
  logic [31:0] out_source_count;
  logic        out_alert;
  logic        out_table_full_drop;

  udp_per_source_flood_counter dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_frame_length     (in_frame_length),
    .in_ether_type       (in_ether_type),
    .in_ip_protocol      (in_ip_protocol),
    .in_ip_header_words  (in_ip_header_words),
    .in_source_address   (in_source_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_counted         (out_counted),
    .out_source_count    (out_source_count),
    .out_alert           (out_alert),
    .out_table_full_drop (out_table_full_drop)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor state: per-source counts, in the order sources got a slot
  // --------------------------------------------------------------------------
  logic [31:0] alert_level = THRESH_RESET;
  logic [31:0] source_counts [logic [31:0]];
  logic [31:0] stored_sources [$];

  frame_hdr_t    pending_frames [$];   // words waiting for the driver
  flood_result_t awaited_results [$];  // predicted results, oldest first

  // stimulus knobs
  logic [31:0] flood_src;
  logic [31:0] hot_sources [5];

  // bookkeeping
  int frames_sent;
  int results_checked;
  int alerts_seen;
  int drops_seen;
  int counted_seen;
  int bad_results;
  int levels_used;

  // driver and stall generator scratch
  logic in_taken = 1'b0;
  int   in_gap;
  int   in_calm;
  int   out_hold;
  int   out_calm;
  int   out_roll;

  // stall / gap length: mostly short, now and then a long one
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 70) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  // --------------------------------------------------------------------------
  // flood counter prediction; updates the table model as the block would
  // --------------------------------------------------------------------------
  function automatic flood_result_t predict_flood_result(frame_hdr_t f);
    flood_result_t r;
    int            udp_end;
    r = '0;
    // udp header sits right behind the ip header, whatever its stated length
    udp_end = int'(UDP_BASE_LEN) + 4 * int'(f.ip_header_words);
    if (f.ether_type != ETYPE_IPV4 || f.ip_protocol != PROTO_UDP ||
        int'(f.frame_length) < int'(MIN_IP_LEN) || int'(f.frame_length) < udp_end) begin
      return r;
    end
    r.counted = 1'b1;
    if (source_counts.exists(f.source_address)) begin
      // counts stick at all ones
      if (source_counts[f.source_address] != COUNT_MAX) begin
        source_counts[f.source_address] = source_counts[f.source_address] + 1;
      end
      r.source_count = source_counts[f.source_address];
    end else begin
      r.source_count = 32'd1;
      if (stored_sources.size() < TABLE_ENTRIES) begin
        source_counts[f.source_address] = 32'd1;
        stored_sources.push_back(f.source_address);
      end else begin
        r.table_full_drop = 1'b1;
      end
    end
    r.alert = (r.source_count == alert_level);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------
  function automatic frame_hdr_t make_frame(int len, int etype, int proto, int words,
                                            logic [31:0] src);
    frame_hdr_t f;
    f.frame_length    = 16'(len);
    f.ether_type      = 16'(etype);
    f.ip_protocol     = 8'(proto);
    f.ip_header_words = 4'(words);
    f.source_address  = src;
    return f;
  endfunction

  // smallest length that still holds the udp header for this ip header length
  function automatic int udp_min_len(int words);
    int need;
    need = int'(UDP_BASE_LEN) + 4 * words;
    return (need < int'(MIN_IP_LEN)) ? int'(MIN_IP_LEN) : need;
  endfunction

  // a complete ipv4/udp frame; lengths mostly near the minimum
  function automatic frame_hdr_t udp_frame(logic [31:0] src);
    int words;
    int lo;
    int len;
    words = $urandom_range(0, 15);
    lo    = udp_min_len(words);
    if ($urandom_range(0, 99) < 85) begin
      len = $urandom_range(lo, lo + 200);
    end else begin
      len = $urandom_range(lo, 65535);
    end
    return make_frame(len, ETYPE_IPV4, PROTO_UDP, words, src);
  endfunction

  // a frame that misses one qualification test, or pure noise
  function automatic frame_hdr_t broken_frame();
    frame_hdr_t f;
    int         words;
    f = udp_frame($urandom);
    case ($urandom_range(0, 3))
      0: begin
        f.ether_type = 16'($urandom);
        if (f.ether_type == ETYPE_IPV4) begin
          f.ether_type = ~ETYPE_IPV4;
        end
      end
      1: begin
        f.ip_protocol = 8'($urandom);
        if (f.ip_protocol == PROTO_UDP) begin
          f.ip_protocol = 8'd6;
        end
      end
      2: begin
        words = int'(f.ip_header_words);
        f.frame_length = 16'($urandom_range(0, udp_min_len(words) - 1));
      end
      default: begin
        f = {$urandom, $urandom, 12'($urandom)};
      end
    endcase
    return f;
  endfunction

  // source mix: one flooding host, a few busy ones, known ones, fresh ones
  function automatic logic [31:0] pick_source();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return flood_src;
    end
    if (roll < 70) begin
      return hot_sources[$urandom_range(0, 4)];
    end
    if (roll < 82 && stored_sources.size() > 0) begin
      return stored_sources[$urandom_range(0, stored_sources.size() - 1)];
    end
    return $urandom;
  endfunction

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        pending_frames.push_back(udp_frame(pick_source()));
      end else begin
        pending_frames.push_back(broken_frame());
      end
    end
  endtask

  task automatic queue_directed();
    // length and header-length edges
    pending_frames.push_back(make_frame(0, 0, 0, 0, 32'h0000_0000));
    pending_frames.push_back(make_frame(65535, 16'hFFFF, 8'hFF, 15, 32'hFFFF_FFFF));
    pending_frames.push_back(make_frame(13, ETYPE_IPV4, PROTO_UDP, 5, 32'h0000_0001));
    pending_frames.push_back(make_frame(33, ETYPE_IPV4, PROTO_UDP, 0, 32'h0000_0001));
    // short ip header: only the length tests matter
    pending_frames.push_back(make_frame(34, ETYPE_IPV4, PROTO_UDP, 0, 32'h0000_0000));
    pending_frames.push_back(make_frame(34, ETYPE_IPV4, PROTO_UDP, 3, 32'h0000_0000));
    pending_frames.push_back(make_frame(34, ETYPE_IPV4, PROTO_UDP, 4, 32'h0000_0000));
    pending_frames.push_back(make_frame(41, ETYPE_IPV4, PROTO_UDP, 5, 32'h0000_0001));
    pending_frames.push_back(make_frame(42, ETYPE_IPV4, PROTO_UDP, 5, 32'h0000_0001));
    // longest ip header, one byte short and exact
    pending_frames.push_back(make_frame(81, ETYPE_IPV4, PROTO_UDP, 15, 32'hFFFF_FFFF));
    pending_frames.push_back(make_frame(82, ETYPE_IPV4, PROTO_UDP, 15, 32'hFFFF_FFFF));
    pending_frames.push_back(make_frame(65535, ETYPE_IPV4, PROTO_UDP, 15, 32'h0000_0000));
    // wrong ethertype / protocol
    pending_frames.push_back(make_frame(100, 16'h86DD, PROTO_UDP, 5, 32'h0000_0001));
    pending_frames.push_back(make_frame(100, 16'h0801, PROTO_UDP, 5, 32'h0000_0001));
    pending_frames.push_back(make_frame(100, ETYPE_IPV4, 6, 5, 32'h0000_0001));
    pending_frames.push_back(make_frame(100, ETYPE_IPV4, 16, 5, 32'h0000_0001));
    pending_frames.push_back(make_frame(100, ETYPE_IPV4, 18, 5, 32'h0000_0001));
    // keys that fold onto the same table index, forcing probe chains, then two other keys
    pending_frames.push_back(make_frame(60, ETYPE_IPV4, PROTO_UDP, 5, 32'h0000_0400));
    pending_frames.push_back(make_frame(60, ETYPE_IPV4, PROTO_UDP, 5, 32'h0010_0000));
    pending_frames.push_back(make_frame(60, ETYPE_IPV4, PROTO_UDP, 5, 32'h0000_0400));
    pending_frames.push_back(make_frame(60, ETYPE_IPV4, PROTO_UDP, 5, 32'h0010_0000));
    pending_frames.push_back(make_frame(60, ETYPE_IPV4, PROTO_UDP, 5, 32'hAAAA_AAAA));
    pending_frames.push_back(make_frame(60, ETYPE_IPV4, PROTO_UDP, 5, 32'h5555_5555));
  endtask

  // threshold write, only done with the block idle
  task automatic set_alert_level(logic [31:0] level);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= level;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    alert_level = level;
    levels_used++;
  endtask

  // wait until every queued word went in and every result came back
  task automatic drain_pipeline();
    while (pending_frames.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic report_bad(string why, flood_result_t want, flood_result_t got);
    bad_results++;
    if (bad_results <= 10) begin
      $display("%0t: %s: expected counted=%0b count=%0d alert=%0b drop=%0b", $realtime,
               why, want.counted, want.source_count, want.alert, want.table_full_drop);
      $display("    got counted=%0b count=%0d alert=%0b drop=%0b",
               got.counted, got.source_count, got.alert, got.table_full_drop);
    end
  endtask

  // --------------------------------------------------------------------------
  // input driver: words change on the falling edge, one per handshake
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    frame_hdr_t f;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap   = in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_frames.size() > 0) begin
        f = pending_frames.pop_front();
        in_frame_length    <= f.frame_length;
        in_ether_type      <= f.ether_type;
        in_ip_protocol     <= f.ip_protocol;
        in_ip_header_words <= f.ip_header_words;
        in_source_address  <= f.source_address;
        in_valid           <= 1'b1;
        // gap after this word: sometimes a run of back-to-back words
        if (in_calm > 0) begin
          in_calm = in_calm - 1;
          in_gap  = 0;
        end else if ($urandom_range(0, 99) < 4) begin
          in_calm = $urandom_range(15, 60);
          in_gap  = 0;
        end else if ($urandom_range(0, 99) < 45) begin
          in_gap = 0;
        end else begin
          in_gap = stall_len();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result-side back-pressure, independent of out_valid
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_stall <= 1'b1;
    end else if (out_calm > 0) begin
      out_calm = out_calm - 1;
      out_stall <= 1'b0;
    end else begin
      out_roll = $urandom_range(0, 99);
      if (out_roll < 3) begin
        out_calm = $urandom_range(20, 80);
        out_stall <= 1'b0;
      end else if (out_roll < 30) begin
        out_hold = stall_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on each accepted input word, check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    flood_result_t want;
    flood_result_t got;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      awaited_results.push_back(predict_flood_result({in_frame_length, in_ether_type,
        in_ip_protocol, in_ip_header_words, in_source_address}));
      frames_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = {out_counted, out_source_count, out_alert, out_table_full_drop};
      results_checked++;
      if (got.counted === 1'b1) counted_seen++;
      if (got.alert === 1'b1) alerts_seen++;
      if (got.table_full_drop === 1'b1) drops_seen++;
      if (awaited_results.size() == 0) begin
        report_bad("result with nothing pending", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.counted !== want.counted || got.source_count !== want.source_count ||
            got.alert !== want.alert || got.table_full_drop !== want.table_full_drop) begin
          report_bad("result mismatch", want, got);
        end
      end
    end
  end

  // watchdog: nothing moving on either channel for too long
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $realtime, STUCK_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    flood_src = $urandom;
    for (int i = 0; i < 5; i++) begin
      hot_sources[i] = $urandom;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset threshold of 50; the flooding host crosses it in here
    queue_directed();
    queue_random(160);
    drain_pipeline();

    // threshold 1: every new source alerts on its first frame
    set_alert_level(32'd1);
    queue_random(80);
    drain_pipeline();

    // all-ones threshold, out of reach
    set_alert_level(32'hFFFF_FFFF);
    queue_random(60);
    drain_pipeline();

    // zero threshold never matches a count
    set_alert_level(32'd0);
    queue_random(50);
    drain_pipeline();

    // just ahead of the flooding host so it trips again
    set_alert_level(source_counts.exists(flood_src) ? source_counts[flood_src] + 32'd6
                                                    : 32'd6);
    queue_random(100);
    drain_pipeline();

    // threshold 2: sources alert on their second frame
    set_alert_level(32'd2);
    queue_random(150);
    drain_pipeline();

    // back to threshold 1 with a well-populated table
    set_alert_level(32'd1);
    queue_random(80);
    drain_pipeline();

    if (awaited_results.size() != 0) begin
      bad_results += awaited_results.size();
      $display("%0d results never arrived", awaited_results.size());
    end
    $display("%0d frames sent over %0d thresholds, %0d results checked, %0d mismatches",
             frames_sent, levels_used + 1, results_checked, bad_results);
    $display("%0d counted, %0d alerts, %0d table-full drops, %0d sources stored",
             counted_seen, alerts_seen, drops_seen, stored_sources.size());
    if (bad_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ufc_pkg.sv
rtl/ufc_ctrl.sv
rtl/ufc_datapath.sv
rtl/udp_per_source_flood_counter.sv
rtl/ufc_checker.sv
bench/tb_udp_per_source_flood_counter.sv
